FILE: rtl/detection_confirm_tracker_core_assert.svh
`ifndef DETECTION_CONFIRM_TRACKER_CORE_ASSERT_SVH
`define DETECTION_CONFIRM_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DCT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define DCT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/dct_pkg.sv
package dct_pkg;

   localparam int CoordWidth = 16;
   localparam int ScoreWidth = 32;
   localparam int CoverWidth = 8;
   localparam int CountWidth = 8;
   localparam int DistWidth  = 2 * CoordWidth;

   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] CsrFramesNeeded = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrJumpLimit    = 1'b1;

   typedef struct packed {
      logic                         detect_valid;
      logic        [CoordWidth-1:0] det_x;
      logic        [CoordWidth-1:0] det_y;
      logic        [CoordWidth-1:0] det_radius;
      logic signed [ScoreWidth-1:0] det_score;
      logic        [CoverWidth-1:0] det_coverage;
   } req_item_type;

   typedef struct packed {
      logic                         stable;
      logic        [CoordWidth-1:0] out_x;
      logic        [CoordWidth-1:0] out_y;
      logic        [CoordWidth-1:0] out_radius;
      logic signed [ScoreWidth-1:0] out_score;
      logic        [CoverWidth-1:0] out_coverage;
   } rsp_item_type;

   function automatic logic [CoordWidth-1:0] smooth(input logic [CoordWidth-1:0] old_v,
                                                    input logic [CoordWidth-1:0] new_v);
      logic [CoordWidth+1:0] acc;
      acc = {2'b00, old_v} + {1'b0, old_v, 1'b0} + {2'b00, new_v};
      return acc[CoordWidth+1:2];
   endfunction

   function automatic logic [CoordWidth-1:0] abs_diff(input logic [CoordWidth-1:0] a,
                                                      input logic [CoordWidth-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

FILE: rtl/dct_track.sv
module dct_track (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  dct_pkg::req_item_type                item,
   input  logic                                 csr_write_en,
   input  logic [dct_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [dct_pkg::CsrDataWidth-1:0]     csr_wdata,
   output dct_pkg::rsp_item_type                result
);
   import dct_pkg::*;

   logic [CountWidth-1:0] frames_needed_ff;
   logic [DistWidth-1:0]  limit_sq_ff;

   logic                  track_held_ff,     track_held_in;
   logic [CountWidth-1:0] run_count_ff,      run_count_in;
   logic [CoordWidth-1:0] track_x_ff,        track_x_in;
   logic [CoordWidth-1:0] track_y_ff,        track_y_in;
   logic [CoordWidth-1:0] track_radius_ff,   track_radius_in;
   logic [ScoreWidth-1:0] track_score_ff,    track_score_in;
   logic [CoverWidth-1:0] track_coverage_ff, track_coverage_in;

   logic [CountWidth-1:0] need;
   logic [CoordWidth-1:0] dist_x;
   logic [CoordWidth-1:0] dist_y;
   logic [DistWidth-1:0]  sq_x;
   logic [DistWidth-1:0]  sq_y;
   logic [DistWidth:0]    dist_sq;
   logic                  near;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_needed_ff <= CountWidth'(1);
         limit_sq_ff      <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CsrFramesNeeded: frames_needed_ff <= csr_wdata[CountWidth-1:0];
            CsrJumpLimit:    limit_sq_ff      <= DistWidth'(csr_wdata) * DistWidth'(csr_wdata);
            default:         ;
         endcase
      end
   end

   assign need   = (frames_needed_ff == '0) ? CountWidth'(1) : frames_needed_ff;
   assign dist_x = abs_diff(item.det_x, track_x_ff);
   assign dist_y = abs_diff(item.det_y, track_y_ff);
   assign sq_x   = DistWidth'(dist_x) * DistWidth'(dist_x);
   assign sq_y   = DistWidth'(dist_y) * DistWidth'(dist_y);
   assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
   assign near   = track_held_ff && (dist_sq <= {1'b0, limit_sq_ff});

   always_comb begin
      track_held_in     = track_held_ff;
      run_count_in      = run_count_ff;
      track_x_in        = track_x_ff;
      track_y_in        = track_y_ff;
      track_radius_in   = track_radius_ff;
      track_score_in    = track_score_ff;
      track_coverage_in = track_coverage_ff;
      priority if (!item.detect_valid) begin
         run_count_in = '0;
      end else if (!near) begin
         track_held_in     = 1'b1;
         run_count_in      = CountWidth'(1);
         track_x_in        = item.det_x;
         track_y_in        = item.det_y;
         track_radius_in   = item.det_radius;
         track_score_in    = item.det_score;
         track_coverage_in = item.det_coverage;
      end else begin
         if (run_count_ff < need) begin
            run_count_in = run_count_ff + CountWidth'(1);
         end
         track_x_in        = smooth(track_x_ff, item.det_x);
         track_y_in        = smooth(track_y_ff, item.det_y);
         track_radius_in   = smooth(track_radius_ff, item.det_radius);
         track_score_in    = item.det_score;
         track_coverage_in = item.det_coverage;
      end
   end

   always_comb begin
      result.stable       = item.detect_valid && (run_count_in >= need);
      result.out_x        = track_x_in;
      result.out_y        = track_y_in;
      result.out_radius   = track_radius_in;
      result.out_score    = track_score_in;
      result.out_coverage = track_coverage_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_held_ff     <= 1'b0;
         run_count_ff      <= '0;
         track_x_ff        <= '0;
         track_y_ff        <= '0;
         track_radius_ff   <= '0;
         track_score_ff    <= '0;
         track_coverage_ff <= '0;
      end else if (advance) begin
         track_held_ff     <= track_held_in;
         run_count_ff      <= run_count_in;
         track_x_ff        <= track_x_in;
         track_y_ff        <= track_y_in;
         track_radius_ff   <= track_radius_in;
         track_score_ff    <= track_score_in;
         track_coverage_ff <= track_coverage_in;
      end
   end

`include "detection_confirm_tracker_core_assert.svh"

   `DCT_ASSERT_NOW(a_no_track_no_count, !track_held_ff, run_count_ff == '0,
                   "Run count set with no track held.")
   `DCT_ASSERT_NEXT(a_hit_holds_track, advance && item.detect_valid, track_held_ff,
                    "Hit did not leave a track held.")
   `DCT_ASSERT_NEXT(a_miss_clears_count, advance && !item.detect_valid, run_count_ff == '0,
                    "Miss did not clear the run count.")

endmodule

FILE: rtl/detection_confirm_tracker_core.sv
// Each item passes from the input register through the track update into the
// result register, from which it is taken when rsp_ready is high.
// Throughput: one item per cycle while the result side takes one per cycle.
// The track update and distance check run combinationally between the input
// and result registers. Synchronous active-high reset empties both stages,
// clears the track and sets frames_needed to 1 and jump_limit to 0.
module detection_confirm_tracker_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  dct_pkg::req_item_type             req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output dct_pkg::rsp_item_type             rsp_data,
   input  logic                              csr_write_en,
   input  logic [dct_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [dct_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import dct_pkg::*;

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type result;
   logic         advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   dct_track u_track (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .item         (in_item_ff),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= result;
      end
   end

`include "detection_confirm_tracker_core_assert.svh"

   `DCT_ASSERT_NOW(a_stall_blocks_input, in_valid_ff && out_valid_ff && !rsp_ready,
                   !req_ready, "Input taken while both stages are stalled.")
   `DCT_ASSERT_NEXT(a_advance_fills_output, advance, out_valid_ff,
                    "Processed item did not reach the result register.")
   `DCT_ASSERT_NEXT(a_drain_empties_output, out_valid_ff && rsp_ready && !advance,
                    !out_valid_ff, "Taken result was not removed.")

endmodule
